[rtl/ttw_pkg.sv]
package ttw_pkg;

	// Screen geometry defaults
	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;

	// Port field widths
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	// Character and attribute codes
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

	// Request kinds
	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Controller phases
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADDR,
		ST_ACCESS,
		ST_DONE
	} ttw_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic addr;
		logic exec;
		logic load;
	} ttw_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} ttw_stat_t;

endpackage

[rtl/ttw_ctrl.sv]
module ttw_ctrl import ttw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ttw_stat_t stat,
	output ttw_cmd_t  cmd
);

	ttw_state_t state_q;
	ttw_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ADDR;
			end
			ST_ADDR:   state_d = ST_ACCESS;
			ST_ACCESS: state_d = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ADDR:   cmd.addr = 1'b1;
			ST_ACCESS: cmd.exec = 1'b1;
			ST_DONE:   cmd.load = stat.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/ttw_dp.sv]
module ttw_dp import ttw_pkg::*; #(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttw_cmd_t          cmd,
	output ttw_stat_t         stat,
	input  logic              action,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ROW_W-1:0]  read_row,
	input  logic [COL_W-1:0]  read_col,
	input  logic              cfg_we,
	input  logic [CHAR_W-1:0] cfg_wdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] cell_data,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [COL_W-1:0]  cursor_col,
	output logic              scrolled
);

	localparam int RW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int CW    = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
	localparam int FW    = $clog2(SCREEN_COLS + 1);
	localparam int DEPTH = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [RW-1:0]    ROW_LAST   = RW'(SCREEN_ROWS - 1);
	localparam logic [CW-1:0]    COL_LAST   = CW'(SCREEN_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST_P = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST_P = COL_W'(SCREEN_COLS - 1);
	localparam logic [RW:0]      ROWS_EXT   = (RW + 1)'(SCREEN_ROWS);

	// Request fields
	logic              act_q;
	logic [CHAR_W-1:0] char_q;
	logic [RW-1:0]     rrow_q;
	logic [CW-1:0]     rcol_q;

	// Terminal state: cursor, physical row of the top line, color
	logic [RW-1:0]     crow_q;
	logic [CW-1:0]     ccol_q;
	logic [RW-1:0]     top_q;
	logic [CHAR_W-1:0] color_q;

	// Per physical row: cells written so far, and blank color
	logic [FW-1:0]     fill_q  [SCREEN_ROWS];
	logic [CHAR_W-1:0] fcolor_q[SCREEN_ROWS];

	// Access stage
	logic [AW-1:0]     addr_q;
	logic [RW-1:0]     phys_q;
	logic              hit_q;
	logic [CHAR_W-1:0] bcolor_q;
	logic [CELL_W-1:0] rdata_q;
	logic              scr_q;

	// Output register
	logic              out_valid_q;
	logic [CELL_W-1:0] cell_q;
	logic [ROW_W-1:0]  orow_q;
	logic [COL_W-1:0]  ocol_q;
	logic              oscr_q;

	// Screen store
	logic [CELL_W-1:0] mem[DEPTH];

	logic [RW-1:0] lrow;
	logic [CW-1:0] lcol;
	logic [RW:0]   row_sum;
	logic [RW-1:0] phys;
	logic [AW-1:0] addr;
	logic [RW-1:0] top_next;
	logic          is_put;
	logic          is_nl;
	logic          wr_en;

	// Logical to physical row, then cell address
	always_comb begin
		lrow    = (act_q == ACT_READ) ? rrow_q : crow_q;
		lcol    = (act_q == ACT_READ) ? rcol_q : ccol_q;
		row_sum = {1'b0, lrow} + {1'b0, top_q};
		if (row_sum >= ROWS_EXT) begin
			row_sum = row_sum - ROWS_EXT;
		end
		phys     = row_sum[RW-1:0];
		addr     = AW'(phys) * AW'(SCREEN_COLS) + AW'(lcol);
		top_next = (top_q == ROW_LAST) ? '0 : top_q + RW'(1);
		is_put   = (act_q == ACT_PUT);
		is_nl    = (char_q == NEWLINE_CODE);
		wr_en    = cmd.exec && is_put && !is_nl;
	end

	// Request capture with read clamping, then the address stage
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			char_q <= char_code;
			rrow_q <= (read_row > ROW_LAST_P) ? ROW_LAST : read_row[RW-1:0];
			rcol_q <= (read_col > COL_LAST_P) ? COL_LAST : read_col[CW-1:0];
		end
		if (cmd.addr) begin
			addr_q   <= addr;
			phys_q   <= phys;
			hit_q    <= (FW'(lcol) < fill_q[phys]);
			bcolor_q <= fcolor_q[phys];
		end
	end

	// Screen memory, one port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q] <= {color_q, char_q};
		end
		if (cmd.exec) begin
			rdata_q <= mem[addr_q];
		end
	end

	// Cursor, scroll and row bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crow_q  <= '0;
			ccol_q  <= '0;
			top_q   <= '0;
			color_q <= RESET_COLOR;
			scr_q   <= 1'b0;
			for (int i = 0; i < SCREEN_ROWS; i++) begin
				fill_q[i]   <= '0;
				fcolor_q[i] <= RESET_COLOR;
			end
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				scr_q <= 1'b0;
				if (is_put) begin
					if (!is_nl) begin
						fill_q[phys_q] <= FW'(ccol_q) + FW'(1);
					end
					if (is_nl || ccol_q == COL_LAST) begin
						ccol_q <= '0;
						if (crow_q == ROW_LAST) begin
							// old top line becomes the blank bottom line
							top_q            <= top_next;
							fill_q[top_q]    <= '0;
							fcolor_q[top_q]  <= color_q;
							scr_q            <= 1'b1;
						end else begin
							crow_q <= crow_q + RW'(1);
						end
					end else begin
						ccol_q <= ccol_q + CW'(1);
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (act_q == ACT_READ) begin
				cell_q <= hit_q ? rdata_q : {bcolor_q, BLANK_CODE};
			end else begin
				cell_q <= '0;
			end
			orow_q <= ROW_W'(crow_q);
			ocol_q <= COL_W'(ccol_q);
			oscr_q <= scr_q;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign cell_data     = cell_q;
	assign cursor_row    = orow_q;
	assign cursor_col    = ocol_q;
	assign scrolled      = oscr_q;

endmodule

[rtl/text_terminal_writer.sv]
// Text terminal writer: a SCREEN_ROWS x SCREEN_COLS store of 16-bit cells
// (color in the high byte, character in the low byte) and a cursor. A put
// request stores its byte at the cursor in the color last written on the
// config port (0x0A is newline), a read request returns one cell, with row
// and column clamped to the screen. Every request yields one result that
// also carries the cursor after the request and a scroll flag. Each request
// passes through capture, address, memory access and result steps in that
// order, and a new request is accepted only once the last one is done; a
// result not yet taken holds the request in its result step. Scrolling
// rotates the physical origin row and marks the new bottom row blank, so it
// needs no copying of rows, and reset needs no clearing pass: rows track
// how many cells were written and unwritten cells read as blanks.
module text_terminal_writer import ttw_pkg::*; #(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ROW_W-1:0]  read_row,
	input  logic [COL_W-1:0]  read_col,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] cell_data,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [COL_W-1:0]  cursor_col,
	output logic              scrolled,
	input  logic              cfg_we,
	input  logic [CHAR_W-1:0] cfg_wdata
);

	ttw_cmd_t  cmd;
	ttw_stat_t stat;

	// Sequencer
	ttw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Screen store, cursor and result register
	ttw_dp #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_data  (cell_data),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

endmodule
